[rtl/core/sles_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sles_pkg
// Shared constants, register codes and helpers for the strip load stress
// pipeline: angle scale 2^30, CORDIC arctangent table, saturation.
// ----------------------------------------------------------------------------
package sles_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int NORM_MSB     = 52;
  localparam int ZW           = 34;

  localparam logic signed [ZW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 34'sd6746518852;
  localparam logic signed [ZW-1:0] GAIN_INV    = 34'sd652032874;
  localparam logic signed [65:0]   INV_PI_Q30  = 66'sd341782638;

  typedef enum logic [2:0] {
    REG_LOAD       = 3'd0,
    REG_HALF_WIDTH = 3'd1,
    REG_X_ORIGIN   = 3'd2,
    REG_Y_ORIGIN   = 3'd3,
    REG_X_STEP     = 3'd4,
    REG_Y_STEP     = 3'd5
  } cfg_reg_t;

  function automatic logic signed [ZW-1:0] atan_at(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:       t = 34'sd843314857;
      1:       t = 34'sd497837829;
      2:       t = 34'sd263043837;
      3:       t = 34'sd133525159;
      4:       t = 34'sd67021687;
      5:       t = 34'sd33543516;
      6:       t = 34'sd16775851;
      7:       t = 34'sd8388437;
      8:       t = 34'sd4194283;
      9:       t = 34'sd2097149;
      default: t = ZW'(64'sd1 <<< (30 - i));
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/core/strip_load_elastic_stress.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_load_elastic_stress
// Principal stresses under a uniform strip load on an elastic half-space,
// one grid point per transaction, fixed point throughout.
// ----------------------------------------------------------------------------
// One grid point (column, row) enters per clock while the output buffer is
// not full; results leave through a two-entry output buffer. Most of the
// latency comes from the two 30-step CORDIC chains, one step per register
// stage, the first for both arctangents side by side and the second for
// the sine. The whole pipeline holds only while the output buffer is full.
// The cfg channel is always ready; the user must write the configuration
// registers only while no point is in flight; the block does not enforce it.
module strip_load_elastic_stress #(
  parameter int COORD_WIDTH = 32,
  parameter int INDEX_BITS  = 10
) (
  input  logic clk,
  input  logic rst,
  // col_index, row_index
  input  logic [((2*INDEX_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // col_echo, row_echo, point_x, point_y, major_stress, minor_stress,
  // max_shear, major_ratio, minor_ratio, shear_ratio
  output logic [((2*INDEX_BITS+2*COORD_WIDTH+192+7)/8)*8-1:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IB    = INDEX_BITS;
  localparam int CW    = COORD_WIDTH;
  localparam int OW    = 2*IB + 2*CW + 192;
  localparam int OTW   = ((OW+7)/8)*8;
  localparam int PW    = 33 + IB;
  localparam int SW    = PW + 1;
  localparam int AW    = (CW > 32 ? CW : 32) + 1;
  localparam int VW    = 56;
  localparam int ZW    = sles_pkg::ZW;
  localparam int STEPS = sles_pkg::CORDIC_STEPS;
  localparam int ST_ALP = 5 + STEPS;
  localparam int LAST  = ST_ALP + STEPS + 3;

  localparam logic signed [63:0] CHI = (64'sd1 <<< (CW-1)) - 64'sd1;
  localparam logic signed [63:0] CLO = -CHI - 64'sd1;

  // configuration
  logic signed [31:0] load, x_origin, y_origin, x_step, y_step;
  logic [30:0] half_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load       <= 32'sd65536;
      half_width <= 31'd65536;
      x_origin   <= 32'sd0;
      y_origin   <= 32'sd0;
      x_step     <= 32'sd0;
      y_step     <= 32'sd3277;
    end else if (cfg_valid) begin
      case (sles_pkg::cfg_reg_t'(cfg_index))
        sles_pkg::REG_LOAD:       load       <= cfg_data;
        sles_pkg::REG_HALF_WIDTH: half_width <= cfg_data[30:0];
        sles_pkg::REG_X_ORIGIN:   x_origin   <= cfg_data;
        sles_pkg::REG_Y_ORIGIN:   y_origin   <= cfg_data;
        sles_pkg::REG_X_STEP:     x_step     <= cfg_data;
        sles_pkg::REG_Y_STEP:     y_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [1:0] cnt;
  logic en, wr, rd, rd_ptr, wr_ptr;
  logic [LAST:0] v;

  assign en       = (cnt != 2'd2);
  assign s_tready = en;
  assign wr       = en && v[LAST];
  assign rd       = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAST-1:0], s_tvalid};
    end
  end

  // index travel
  logic [IB-1:0] s_col, s_row;
  logic [IB:0] row_p1;
  logic [IB-1:0] col_p [0:LAST];
  logic [IB-1:0] row_p [0:LAST];
  logic signed [CW-1:0] px_p [1:LAST];
  logic signed [CW-1:0] py_p [1:LAST];

  assign s_col  = s_tdata[IB-1:0];
  assign s_row  = s_tdata[2*IB-1:IB];
  assign row_p1 = {1'b0, s_row} + (IB+1)'(1);

  // stage 0: grid products
  logic signed [PW-1:0] prodx, prody;
  // stage 1: coordinates
  logic signed [SW-1:0] sumx, sumy;
  logic signed [CW-1:0] satx, saty;

  always_comb begin
    sumx = SW'(x_origin) + SW'(prodx);
    sumy = SW'(y_origin) + SW'(prody);
    if (64'(sumx) > CHI) satx = CW'(CHI);
    else if (64'(sumx) < CLO) satx = CW'(CLO);
    else satx = CW'(sumx);
    if (64'(sumy) > CHI) saty = CW'(CHI);
    else if (64'(sumy) < CLO) saty = CW'(CLO);
    else saty = CW'(sumy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_p[0] <= s_col;
      row_p[0] <= s_row;
      for (int i = 1; i <= LAST; i++) begin
        col_p[i] <= col_p[i-1];
        row_p[i] <= row_p[i-1];
      end
      px_p[1] <= satx;
      py_p[1] <= saty;
      for (int i = 2; i <= LAST; i++) begin
        px_p[i] <= px_p[i-1];
        py_p[i] <= py_p[i-1];
      end
      prodx <= x_step * $signed({1'b0, s_col});
      prody <= y_step * $signed({1'b0, row_p1});
    end
  end

  // stage 2: offsets to both strip edges, magnitudes
  logic signed [AW-1:0] a_n, c_n, ea_r, ec_r;
  logic signed [CW-1:0] ey_r;
  logic [AW-1:0] aa, ac, ay, m1_n, m2_n, m1_r, m2_r;
  logic zf1_2, zf2_2;

  always_comb begin
    a_n  = AW'(px_p[1]) + AW'($signed({1'b0, half_width}));
    c_n  = AW'(px_p[1]) - AW'($signed({1'b0, half_width}));
    aa   = a_n[AW-1] ? AW'(-a_n) : AW'(a_n);
    ac   = c_n[AW-1] ? AW'(-c_n) : AW'(c_n);
    ay   = py_p[1][CW-1] ? AW'(-AW'(py_p[1])) : AW'(py_p[1]);
    m1_n = (aa > ay) ? aa : ay;
    m2_n = (ac > ay) ? ac : ay;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea_r  <= a_n;
      ec_r  <= c_n;
      ey_r  <= py_p[1];
      m1_r  <= m1_n;
      m2_r  <= m2_n;
      zf1_2 <= (a_n == '0) && (py_p[1] == '0);
      zf2_2 <= (c_n == '0) && (py_p[1] == '0);
    end
  end

  // stage 3: normalize so the larger magnitude reaches 2^52
  function automatic logic [5:0] msb_of(input logic [AW-1:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < AW; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  logic [5:0] k1, k2;
  logic signed [VW-1:0] nx1, ny1, nx2, ny2;
  logic zf1_3, zf2_3;

  assign k1 = 6'(sles_pkg::NORM_MSB) - msb_of(m1_r);
  assign k2 = 6'(sles_pkg::NORM_MSB) - msb_of(m2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      nx1   <= VW'(ea_r) <<< k1;
      ny1   <= VW'(ey_r) <<< k1;
      nx2   <= VW'(ec_r) <<< k2;
      ny2   <= VW'(ey_r) <<< k2;
      zf1_3 <= zf1_2;
      zf2_3 <= zf2_2;
    end
  end

  // stage 4: quadrant turn, then vectoring steps
  logic signed [VW-1:0] vx1 [0:STEPS];
  logic signed [VW-1:0] vy1 [0:STEPS];
  logic signed [ZW-1:0] vz1 [0:STEPS];
  logic signed [VW-1:0] vx2 [0:STEPS];
  logic signed [VW-1:0] vy2 [0:STEPS];
  logic signed [ZW-1:0] vz2 [0:STEPS];
  logic zf1 [0:STEPS];
  logic zf2 [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      zf1[0] <= zf1_3;
      zf2[0] <= zf2_3;
      if (!nx1[VW-1]) begin
        vx1[0] <= nx1; vy1[0] <= ny1; vz1[0] <= '0;
      end else if (!ny1[VW-1]) begin
        vx1[0] <= ny1; vy1[0] <= -nx1; vz1[0] <= sles_pkg::ANG_HALF_PI;
      end else begin
        vx1[0] <= -ny1; vy1[0] <= nx1; vz1[0] <= -sles_pkg::ANG_HALF_PI;
      end
      if (!nx2[VW-1]) begin
        vx2[0] <= nx2; vy2[0] <= ny2; vz2[0] <= '0;
      end else if (!ny2[VW-1]) begin
        vx2[0] <= ny2; vy2[0] <= -nx2; vz2[0] <= sles_pkg::ANG_HALF_PI;
      end else begin
        vx2[0] <= -ny2; vy2[0] <= nx2; vz2[0] <= -sles_pkg::ANG_HALF_PI;
      end
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        zf1[g+1] <= zf1[g];
        zf2[g+1] <= zf2[g];
        if (!vy1[g][VW-1]) begin
          vx1[g+1] <= vx1[g] + (vy1[g] >>> g);
          vy1[g+1] <= vy1[g] - (vx1[g] >>> g);
          vz1[g+1] <= vz1[g] + sles_pkg::atan_at(g);
        end else begin
          vx1[g+1] <= vx1[g] - (vy1[g] >>> g);
          vy1[g+1] <= vy1[g] + (vx1[g] >>> g);
          vz1[g+1] <= vz1[g] - sles_pkg::atan_at(g);
        end
        if (!vy2[g][VW-1]) begin
          vx2[g+1] <= vx2[g] + (vy2[g] >>> g);
          vy2[g+1] <= vy2[g] - (vx2[g] >>> g);
          vz2[g+1] <= vz2[g] + sles_pkg::atan_at(g);
        end else begin
          vx2[g+1] <= vx2[g] - (vy2[g] >>> g);
          vy2[g+1] <= vy2[g] + (vx2[g] >>> g);
          vz2[g+1] <= vz2[g] - sles_pkg::atan_at(g);
        end
      end
    end
  end

  // subtended angle, wrap and fold for the sine
  logic signed [ZW-1:0] al, aw, af;

  always_comb begin
    al = (zf1[STEPS] ? ZW'(0) : vz1[STEPS]) - (zf2[STEPS] ? ZW'(0) : vz2[STEPS]);
    if (al > sles_pkg::ANG_PI) aw = al - sles_pkg::ANG_TWO_PI;
    else if (al < -sles_pkg::ANG_PI) aw = al + sles_pkg::ANG_TWO_PI;
    else aw = al;
    if (aw > sles_pkg::ANG_HALF_PI) af = sles_pkg::ANG_PI - aw;
    else if (aw < -sles_pkg::ANG_HALF_PI) af = -sles_pkg::ANG_PI - aw;
    else af = aw;
  end

  logic signed [ZW-1:0] sx [0:STEPS];
  logic signed [ZW-1:0] sy [0:STEPS];
  logic signed [ZW-1:0] sz [0:STEPS];
  logic signed [ZW-1:0] alpha_p [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]      <= sles_pkg::GAIN_INV;
      sy[0]      <= '0;
      sz[0]      <= af;
      alpha_p[0] <= al;
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_sin
    always_ff @(posedge clk) begin
      if (en) begin
        alpha_p[g+1] <= alpha_p[g];
        if (!sz[g][ZW-1]) begin
          sx[g+1] <= sx[g] - (sy[g] >>> g);
          sy[g+1] <= sy[g] + (sx[g] >>> g);
          sz[g+1] <= sz[g] - sles_pkg::atan_at(g);
        end else begin
          sx[g+1] <= sx[g] + (sy[g] >>> g);
          sy[g+1] <= sy[g] - (sx[g] >>> g);
          sz[g+1] <= sz[g] + sles_pkg::atan_at(g);
        end
      end
    end
  end

  // scaling by 1/pi, then by load for the stresses; the ratios skip the load
  logic signed [65:0] pr1, pr3, prs;
  logic signed [35:0] q1, q3, qs;
  logic signed [67:0] ld1, ld3, lds;
  logic signed [31:0] r1, r3, rs;
  logic signed [ZW:0] apl, amn;

  assign apl = (ZW+1)'(alpha_p[STEPS]) + (ZW+1)'(sy[STEPS]);
  assign amn = (ZW+1)'(alpha_p[STEPS]) - (ZW+1)'(sy[STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      pr1 <= 66'(apl) * sles_pkg::INV_PI_Q30;
      pr3 <= 66'(amn) * sles_pkg::INV_PI_Q30;
      prs <= 66'(sy[STEPS]) * sles_pkg::INV_PI_Q30;
      q1  <= 36'((pr1 + 66'sd536870912) >>> 30);
      q3  <= 36'((pr3 + 66'sd536870912) >>> 30);
      qs  <= 36'((prs + 66'sd536870912) >>> 30);
      ld1 <= 68'(load) * 68'(q1);
      ld3 <= 68'(load) * 68'(q3);
      lds <= 68'(load) * 68'(qs);
      r1  <= sles_pkg::sat32(-((72'(q1) + 72'sd2) >>> 2));
      r3  <= sles_pkg::sat32(-((72'(q3) + 72'sd2) >>> 2));
      rs  <= sles_pkg::sat32(-((72'(qs) + 72'sd2) >>> 2));
    end
  end

  logic signed [31:0] st1, st3, sts;
  logic [OW-1:0] res;

  assign st1 = sles_pkg::sat32(-((72'(ld1) + 72'sd536870912) >>> 30));
  assign st3 = sles_pkg::sat32(-((72'(ld3) + 72'sd536870912) >>> 30));
  assign sts = sles_pkg::sat32(-((72'(lds) + 72'sd536870912) >>> 30));
  assign res = {rs, r3, r1, sts, st3, st1, py_p[LAST], px_p[LAST],
                row_p[LAST], col_p[LAST]};

  // output buffer
  logic [OW-1:0] obuf [0:1];

  always_ff @(posedge clk) begin
    if (wr) obuf[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = OTW'(obuf[rd_ptr]);

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("output buffer count out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[0]) else $error("accepted point lost");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> (cnt == $past(cnt) - 2'd1))
    else $error("output buffer count did not drop");
`endif

endmodule
